// ----- rtl/sis_pkg.sv -----
// ----------------------------------------------------------------------------
// sis_pkg: shared types and constants of the sorted insertion store
// request and response payloads, status codes and sizing constants
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int VAL_W        = 32;
  localparam int POS_W        = 4;
  localparam int DEF_CAPACITY = 16;
  localparam int MAX_RESULTS  = 16;

  // request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_ENTRY    = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic                    req_type;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_out;
    logic [POS_W-1:0]        position;
    logic                    last;
    status_t                 status;
  } rsp_t;

endpackage

// ----- rtl/sis_ram.sv -----
// ----------------------------------------------------------------------------
// sis_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/sorted_insertion_store.sv -----
// ----------------------------------------------------------------------------
// sorted_insertion_store: bounded sorted list of signed 32-bit values
// insert and readout requests served by a sequencer over one ram
// ----------------------------------------------------------------------------
// usage
//   req channel (valid/ready): one transaction is an insert (req_type 0) or
//     a readout (req_type 1); the block takes a request only when idle
//   rsp channel (valid/ready): an insert gives one response (inserted, or
//     full and dropped); a readout gives one response per stored value, up to
//     MAX_RESULTS, in order, the final one with last set, or one empty response
//   cfg_we/cfg_data: write descending_order only while idle; not enforced
// sequence
//   an insert landing at position p in a store of n values makes p+1
//   search steps (n when it lands last) and n-p shift steps, then places
//   the value and loads the response; each search and shift step is one
//   ram read followed by a compare or write
//   a readout reads each stored value through the registered read, then sends it
//   a full-store insert or empty readout loads its response with no search
//   the next request is taken once the sequencer is back in idle
// reset clears the count (store empty) and selects descending order;
// a stalled receiver holds the output register and the sequencer waits on it
// ----------------------------------------------------------------------------
module sorted_insertion_store #(
  parameter int CAPACITY = sis_pkg::DEF_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sis_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sis_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic          cfg_data
);

  import sis_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_EMIT,
    S_READ_RD,
    S_READ_OUT
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        count;       // stored values
  logic [CNT_W-1:0]        idx;         // search / readout cursor
  logic [CNT_W-1:0]        pos;         // insert position
  logic [CNT_W-1:0]        shi;         // shift destination
  logic                    desc;        // descending_order register
  logic signed [VAL_W-1:0] val;         // value being inserted
  rsp_t                    pend;        // response waiting for the output register

  // ram ports
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [VAL_W-1:0]  ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [VAL_W-1:0]  ram_rd_data;

  logic             slot_free;
  logic             rsp_load;
  logic             follows;
  logic [CNT_W:0]   idx_inc;
  logic [CNT_W-1:0] shi_dec;
  logic             read_last;

  sis_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign req_ready = (state == S_IDLE);
  // output register can take a new response this cycle
  assign slot_free = !rsp_valid || rsp_ready;
  // a response is loaded into the output register this cycle
  assign rsp_load  = ((state == S_EMIT) || (state == S_READ_OUT)) && slot_free;

  // shared compare: new value strictly follows the stored one
  assign follows = desc ? (val < $signed(ram_rd_data)) : (val > $signed(ram_rd_data));

  assign idx_inc = {1'b0, idx} + 1'b1;
  assign shi_dec = shi - 1'b1;
  // readout ends at the stored count or at the result limit
  assign read_last = (idx_inc == {1'b0, count}) || (int'(idx_inc) == MAX_RESULTS);

  // ram control follows the sequencer state
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = idx[ADDR_W-1:0];
    ram_wr_en   = 1'b0;
    ram_wr_addr = pos[ADDR_W-1:0];
    ram_wr_data = val;
    unique case (state)
      S_SRCH_RD, S_READ_RD: begin
        ram_rd_en = 1'b1;
      end
      S_SHIFT_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = shi_dec[ADDR_W-1:0];
      end
      S_SHIFT_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = shi[ADDR_W-1:0];
        ram_wr_data = ram_rd_data;
      end
      S_PLACE: begin
        ram_wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      count     <= '0;
      desc      <= 1'b1;
    end else begin
      if (cfg_we) begin
        desc <= cfg_data;
      end
      // output register: a new response wins over the handover of the old one
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            val <= req.value;
            idx <= '0;
            pos <= '0;
            if (req.req_type == REQ_READ) begin
              if (count == '0) begin
                pend.value_out <= '0;
                pend.position  <= '0;
                pend.last      <= 1'b1;
                pend.status    <= ST_EMPTY;
                state          <= S_EMIT;
              end else begin
                state <= S_READ_RD;
              end
            end else if (count == CNT_W'(CAPACITY)) begin
              // full: drop and flag
              pend.value_out <= req.value;
              pend.position  <= '0;
              pend.last      <= 1'b1;
              pend.status    <= ST_FULL;
              state          <= S_EMIT;
            end else if (count == '0) begin
              state <= S_PLACE;
            end else begin
              state <= S_SRCH_RD;
            end
          end
        end
        S_SRCH_RD: begin
          state <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (follows) begin
            if (idx_inc == {1'b0, count}) begin
              // goes after every stored value, nothing to shift
              pos   <= count;
              state <= S_PLACE;
            end else begin
              idx   <= idx_inc[CNT_W-1:0];
              state <= S_SRCH_RD;
            end
          end else begin
            pos   <= idx;
            shi   <= count;
            state <= S_SHIFT_RD;
          end
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          shi <= shi_dec;
          if (shi_dec == pos) begin
            state <= S_PLACE;
          end else begin
            state <= S_SHIFT_RD;
          end
        end
        S_PLACE: begin
          count          <= count + 1'b1;
          pend.value_out <= val;
          pend.position  <= POS_W'(pos);
          pend.last      <= 1'b1;
          pend.status    <= ST_INSERTED;
          state          <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            rsp   <= pend;
            state <= S_IDLE;
          end
        end
        S_READ_RD: begin
          state <= S_READ_OUT;
        end
        S_READ_OUT: begin
          if (slot_free) begin
            rsp.value_out <= $signed(ram_rd_data);
            rsp.position  <= POS_W'(idx);
            rsp.last      <= read_last;
            rsp.status    <= ST_ENTRY;
            if (read_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx_inc[CNT_W-1:0];
              state <= S_READ_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // store never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // count only ever grows by one at a time
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == CNT_W'($past(count) + 1'b1)))
    else $error("entry count changed by other than one");

  // an insert into a full store leaves the count alone
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req.req_type == REQ_INSERT)
     && (count == CNT_W'(CAPACITY))) |=> (count == $past(count)))
    else $error("full-store insert changed the count");

endmodule
